// ===== src/ssp_pkg.sv =====
// Shared types, character codes and the default palette for the sixel painter.
package ssp_pkg;

    localparam logic [7:0] CH_REPEAT = 8'h21;
    localparam logic [7:0] CH_ATTR   = 8'h22;
    localparam logic [7:0] CH_COLOUR = 8'h23;
    localparam logic [7:0] CH_CR     = 8'h24;
    localparam logic [7:0] CH_NL     = 8'h2D;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] DATA_LO   = 8'h3F;
    localparam logic [7:0] DATA_HI   = 8'h7E;

    localparam logic [15:0] CS_HLS = 16'd1;
    localparam logic [15:0] CS_RGB = 16'd2;

    typedef enum logic [3:0] {
        M_GROUND = 4'b0001,
        M_REPEAT = 4'b0010,
        M_ATTR   = 4'b0100,
        M_COLOUR = 4'b1000
    } t_mode;

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_PRE    = 13'b0000000000010,
        S_GROUND = 13'b0000000000100,
        S_POST   = 13'b0000000001000,
        S_FIN    = 13'b0000000010000,
        S_H1     = 13'b0000000100000,
        S_H2     = 13'b0000001000000,
        S_H3     = 13'b0000010000000,
        S_H4     = 13'b0000100000000,
        S_WR     = 13'b0001000000000,
        S_RD     = 13'b0010000000000,
        S_RD2    = 13'b0100000000000,
        S_CLEAR  = 13'b1000000000000
    } t_state;

    typedef struct packed {
        logic load;
        logic pre;
        logic ground;
        logic fin;
        logic h1;
        logic h2;
        logic h3;
        logic h4;
        logic wr;
        logic rd;
        logic rd2;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic pre_done;
        logic pre_fin;
        logic out_free;
        logic last;
        logic mode_colour;
        logic define;
        logic hls;
    } t_stat;

    // packed as {blue, green, red}
    function automatic logic [23:0] f_default_rgb(input logic [3:0] idx);
        logic [23:0] v;
        unique case (idx)
            4'd0:    v = {8'd0,   8'd0,   8'd0};
            4'd1:    v = {8'd204, 8'd51,  8'd51};
            4'd2:    v = {8'd33,  8'd33,  8'd204};
            4'd3:    v = {8'd51,  8'd204, 8'd51};
            4'd4:    v = {8'd204, 8'd51,  8'd204};
            4'd5:    v = {8'd204, 8'd204, 8'd51};
            4'd6:    v = {8'd51,  8'd204, 8'd204};
            4'd7:    v = {8'd135, 8'd135, 8'd135};
            4'd8:    v = {8'd66,  8'd66,  8'd66};
            4'd9:    v = {8'd153, 8'd84,  8'd84};
            4'd10:   v = {8'd66,  8'd66,  8'd153};
            4'd11:   v = {8'd84,  8'd153, 8'd84};
            4'd12:   v = {8'd153, 8'd84,  8'd153};
            4'd13:   v = {8'd153, 8'd153, 8'd84};
            4'd14:   v = {8'd84,  8'd153, 8'd153};
            default: v = {8'd204, 8'd204, 8'd204};
        endcase
        return v;
    endfunction

endpackage

// ===== src/ssp_ctrl.sv =====
// Sequencer for byte parsing, colour definition and image clear.
module ssp_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  ssp_pkg::t_stat i_stat,
    output ssp_pkg::t_cmd  o_cmd,
    output logic          o_in_stall
);
    import ssp_pkg::*;

    t_state r_state, n_state;
    logic   r_ret_clear, n_ret_clear;

    always_comb begin
        n_state     = r_state;
        n_ret_clear = r_ret_clear;
        unique case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_PRE;
            S_PRE: begin
                if (i_stat.pre_done) begin
                    n_state = S_POST;
                end else if (i_stat.pre_fin) begin
                    n_state     = S_FIN;
                    n_ret_clear = 1'b0;
                end else begin
                    n_state = S_GROUND;
                end
            end
            S_GROUND: if (i_stat.out_free) n_state = S_POST;
            S_POST: begin
                if (i_stat.last && i_stat.mode_colour) begin
                    n_state     = S_FIN;
                    n_ret_clear = 1'b1;
                end else if (i_stat.last) begin
                    n_state = S_CLEAR;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_FIN:    n_state = S_H1;
            S_H1: begin
                if (!i_stat.define) n_state = S_RD;
                else if (i_stat.hls) n_state = S_H2;
                else n_state = S_WR;
            end
            S_H2:     n_state = S_H3;
            S_H3:     n_state = S_H4;
            S_H4:     n_state = S_WR;
            S_WR:     n_state = r_ret_clear ? S_CLEAR : S_GROUND;
            S_RD:     n_state = S_RD2;
            S_RD2:    n_state = r_ret_clear ? S_CLEAR : S_GROUND;
            S_CLEAR:  n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ret_clear <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ret_clear <= n_ret_clear;
        end
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.load   = (r_state == S_IDLE) && i_in_valid;
        o_cmd.pre    = (r_state == S_PRE);
        o_cmd.ground = (r_state == S_GROUND) && i_stat.out_free;
        o_cmd.fin    = (r_state == S_FIN);
        o_cmd.h1     = (r_state == S_H1);
        o_cmd.h2     = (r_state == S_H2);
        o_cmd.h3     = (r_state == S_H3);
        o_cmd.h4     = (r_state == S_H4);
        o_cmd.wr     = (r_state == S_WR);
        o_cmd.rd     = (r_state == S_RD);
        o_cmd.rd2    = (r_state == S_RD2);
        o_cmd.clear  = (r_state == S_CLEAR);
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

// ===== src/ssp_datapath.sv =====
// Parser registers, palette memory, colour arithmetic and result register.
module ssp_datapath #(
    parameter int MAX_WIDTH       = 1024,
    parameter int MAX_HEIGHT      = 1024,
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ssp_pkg::t_cmd  i_cmd,
    output ssp_pkg::t_stat o_stat,
    input  logic [7:0]     i_stream_byte,
    input  logic           i_end_of_image,
    input  logic [10:0]    i_canvas_width,
    input  logic [10:0]    i_canvas_height,
    input  logic           i_out_stall,
    output logic           o_out_valid,
    output logic [9:0]     o_x_start,
    output logic [10:0]    o_run_length,
    output logic [9:0]     o_band_top,
    output logic [5:0]     o_row_mask,
    output logic [7:0]     o_red,
    output logic [7:0]     o_green,
    output logic [7:0]     o_blue
);
    import ssp_pkg::*;

    localparam int IW   = $clog2(PALETTE_ENTRIES);
    localparam int PREC = (2**20 + PALETTE_ENTRIES - 1) / PALETTE_ENTRIES;

    t_mode       r_mode;
    logic [2:0]  r_fi;
    logic [15:0] r_acc;
    logic        r_ds;
    logic [7:0]  r_dr;
    logic [15:0] r_cs, r_v1, r_v2, r_v3;
    logic [15:0] r_rep, r_col, r_band;
    logic [23:0] r_cur;
    logic        r_use_rep;
    logic [7:0]  r_byte;
    logic        r_last;

    logic [23:0] r_pal [PALETTE_ENTRIES];
    logic [PALETTE_ENTRIES-1:0] r_pal_ok;
    logic [23:0] r_rd_data;
    logic        r_rd_ok;
    logic [IW-1:0] r_idx;

    logic [16:0] r_lq, r_sq, r_vh, r_c, r_x, r_mm;
    logic [7:0]  r_hq;
    logic [8:0]  r_hh;
    logic [2:0]  r_sector;
    logic [23:0] r_new;

    logic        r_out_valid;
    logic [9:0]  r_x_start, r_band_top;
    logic [10:0] r_run_length;
    logic [5:0]  r_row_mask;
    logic [23:0] r_out_rgb;

    logic is_digit, is_data, is_semi;
    logic [19:0] acc_next_w;
    logic [15:0] acc_next;

    assign is_digit = (r_byte >= CH_ZERO) && (r_byte <= CH_NINE);
    assign is_data  = (r_byte >= DATA_LO) && (r_byte <= DATA_HI);
    assign is_semi  = (r_byte == CH_SEMI);
    assign acc_next_w = {r_acc, 3'b000} + {3'b000, r_acc, 1'b0}
                      + {16'd0, r_byte[3:0] - CH_ZERO[3:0]};
    assign acc_next = (acc_next_w > 20'd65535) ? 16'hFFFF : acc_next_w[15:0];

    always_comb begin
        o_stat             = '0;
        o_stat.pre_done    = ((r_mode == M_REPEAT) && is_digit)
                           || ((r_mode == M_ATTR) && (is_digit || (is_semi && r_fi < 3'd3)))
                           || ((r_mode == M_COLOUR) && (is_digit || (is_semi && r_fi < 3'd4)));
        o_stat.pre_fin     = (r_mode == M_COLOUR) && !is_digit && !(is_semi && r_fi < 3'd4);
        o_stat.out_free    = !r_out_valid || !i_out_stall;
        o_stat.last        = r_last;
        o_stat.mode_colour = (r_mode == M_COLOUR);
        o_stat.define      = (r_fi >= 3'd1) && ((r_cs == CS_HLS) || (r_cs == CS_RGB));
        o_stat.hls         = (r_cs == CS_HLS);
    end

    // painting
    logic [15:0] w_eff, h_eff, paint_rep, len_room, run_len;
    logic [5:0]  bits, mask;
    logic [16:0] col_sum;
    logic        paint_go;

    assign w_eff = ({5'd0, i_canvas_width} > 16'(MAX_WIDTH)) ? 16'(MAX_WIDTH)
                                                             : {5'd0, i_canvas_width};
    assign h_eff = ({5'd0, i_canvas_height} > 16'(MAX_HEIGHT)) ? 16'(MAX_HEIGHT)
                                                               : {5'd0, i_canvas_height};
    assign paint_rep = r_use_rep ? r_rep : 16'd1;
    assign bits      = 6'(r_byte - DATA_LO);
    assign len_room  = w_eff - r_col;
    assign run_len   = (paint_rep < len_room) ? paint_rep : len_room;
    assign col_sum   = {1'b0, r_col} + {1'b0, paint_rep};

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            mask[i] = bits[i] && (({1'b0, r_band} + 17'(i)) < {1'b0, h_eff});
        end
    end
    assign paint_go = (r_use_rep || is_data) && (paint_rep != 16'd0) && (bits != 6'd0)
                    && (r_col < w_eff) && (mask != 6'd0);

    // colour arithmetic
    function automatic logic [6:0] f_clamp(input logic [15:0] v);
        return (v > 16'd100) ? 7'd100 : v[6:0];
    endfunction

    function automatic logic [7:0] f_pct(input logic [6:0] a);
        logic [14:0] p;
        logic [27:0] q;
        p = {a, 8'd0} - {8'd0, a};
        q = 28'(p) * 28'd5243;
        return q[26:19];
    endfunction

    function automatic logic [16:0] f_q16(input logic [6:0] a);
        logic [16:0] base;
        logic [21:0] fr;
        base = 17'(a) * 17'd655;
        fr   = 22'(11'(a) * 11'd9) * 22'd1311;
        return base + 17'(fr[21:15]);
    endfunction

    function automatic logic [7:0] f_byte(input logic [17:0] s);
        logic [25:0] p;
        p = {s, 8'd0} - {8'd0, s};
        return (p[25:16] > 10'd255) ? 8'd255 : p[23:16];
    endfunction

    logic [33:0] hq_prod;
    logic [8:0]  hh_w;
    logic [17:0] twol;
    logic [16:0] t_w, one_minus_t;
    logic [33:0] c_prod;
    logic [6:0]  hm;
    logic [16:0] m_w, d_w, one_minus_d;
    logic [20:0] m_fr;
    logic [33:0] x_prod;
    logic [2:0]  sector_w;
    logic [16:0] rv, gv, bv;
    logic [27:0] idx_prod;
    logic [7:0]  idx_q;
    logic [15:0] idx_full;
    logic [16:0] vh_w;

    assign vh_w    = {1'b0, r_v1} + 17'd240;
    assign hq_prod = 34'(vh_w) * 34'd93207;
    assign idx_prod = 28'(r_dr) * 28'(PREC);
    assign idx_q    = idx_prod[27:20];
    assign idx_full = 16'(r_dr) - 16'(idx_q) * 16'(PALETTE_ENTRIES);

    assign hh_w        = 9'(r_vh - 17'(r_hq) * 17'd360);
    assign twol        = {r_lq, 1'b0};
    assign t_w         = (twol >= 18'd65536) ? 17'(twol - 18'd65536) : 17'(18'd65536 - twol);
    assign one_minus_t = 17'd65536 - t_w;
    assign c_prod      = 34'(one_minus_t) * 34'(r_sq);

    assign hm = (r_hh >= 9'd240) ? 7'(r_hh - 9'd240)
              : (r_hh >= 9'd120) ? 7'(r_hh - 9'd120) : r_hh[6:0];
    assign m_fr = 21'({hm, 2'b00}) * 21'd4370;
    assign m_w  = 17'(hm) * 17'd1092 + 17'(m_fr[20:16]);
    assign d_w  = (m_w >= 17'd65536) ? m_w - 17'd65536 : 17'd65536 - m_w;
    assign one_minus_d = 17'd65536 - d_w;
    assign x_prod = 34'(r_c) * 34'(one_minus_d);
    assign sector_w = (r_hh >= 9'd300) ? 3'd5 : (r_hh >= 9'd240) ? 3'd4
                    : (r_hh >= 9'd180) ? 3'd3 : (r_hh >= 9'd120) ? 3'd2
                    : (r_hh >= 9'd60)  ? 3'd1 : 3'd0;

    always_comb begin
        rv = '0;
        gv = '0;
        bv = '0;
        unique case (r_sector)
            3'd0:    begin rv = r_c; gv = r_x; end
            3'd1:    begin rv = r_x; gv = r_c; end
            3'd2:    begin gv = r_c; bv = r_x; end
            3'd3:    begin gv = r_x; bv = r_c; end
            3'd4:    begin rv = r_x; bv = r_c; end
            default: begin rv = r_c; bv = r_x; end
        endcase
    end

    // palette memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_pal[r_idx] <= r_new;
        end
        if (i_cmd.rd) begin
            r_rd_data <= r_pal[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_byte <= i_stream_byte;
        end
        if (i_cmd.h1) begin
            r_idx <= idx_full[IW-1:0];
            r_lq  <= f_q16(f_clamp(r_v2));
            r_sq  <= f_q16(f_clamp(r_v3));
            r_vh  <= vh_w;
            r_hq  <= hq_prod[32:25];
            r_new <= {f_pct(f_clamp(r_v3)), f_pct(f_clamp(r_v2)), f_pct(f_clamp(r_v1))};
        end
        if (i_cmd.h2) begin
            r_hh <= hh_w;
            r_c  <= c_prod[32:16];
        end
        if (i_cmd.h3) begin
            r_sector <= sector_w;
            r_x      <= x_prod[32:16];
            r_mm     <= r_lq - {1'b0, r_c[16:1]};
        end
        if (i_cmd.h4) begin
            r_new <= {f_byte({1'b0, bv} + {1'b0, r_mm}),
                      f_byte({1'b0, gv} + {1'b0, r_mm}),
                      f_byte({1'b0, rv} + {1'b0, r_mm})};
        end
        if (i_cmd.ground && paint_go) begin
            r_x_start    <= r_col[9:0];
            r_run_length <= run_len[10:0];
            r_band_top   <= r_band[9:0];
            r_row_mask   <= mask;
            r_out_rgb    <= r_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_mode    <= M_GROUND;
            r_fi      <= '0;
            r_acc     <= '0;
            r_ds      <= 1'b0;
            r_dr      <= '0;
            r_cs      <= '0;
            r_v1      <= '0;
            r_v2      <= '0;
            r_v3      <= '0;
            r_rep     <= 16'd1;
            r_col     <= '0;
            r_band    <= '0;
            r_cur     <= '0;
            r_use_rep <= 1'b0;
            r_pal_ok  <= '0;
            r_rd_ok   <= 1'b0;
            if (!i_rst_n) begin
                r_last <= 1'b0;
            end
        end else begin
            if (i_cmd.load) begin
                r_last <= i_end_of_image;
            end
            if (i_cmd.pre) begin
                unique case (r_mode)
                    M_REPEAT: begin
                        if (is_digit) begin
                            r_acc <= acc_next;
                            r_ds  <= 1'b1;
                        end else begin
                            r_rep     <= r_ds ? r_acc : 16'd1;
                            r_mode    <= M_GROUND;
                            r_use_rep <= is_data;
                        end
                    end
                    M_ATTR: begin
                        if (!is_digit) begin
                            if (is_semi && r_fi < 3'd3) r_fi <= r_fi + 3'd1;
                            else r_mode <= M_GROUND;
                        end
                    end
                    M_COLOUR: begin
                        if (is_digit) begin
                            r_acc <= acc_next;
                            r_ds  <= 1'b1;
                        end else if (is_semi && r_fi < 3'd4) begin
                            unique case (r_fi)
                                3'd0:    r_dr <= r_acc[7:0];
                                3'd1:    r_cs <= r_acc;
                                3'd2:    r_v1 <= r_acc;
                                default: r_v2 <= r_acc;
                            endcase
                            r_acc <= '0;
                            r_ds  <= 1'b0;
                            r_fi  <= r_fi + 3'd1;
                        end
                    end
                    default: ;
                endcase
            end
            if (i_cmd.fin) begin
                unique case (r_fi)
                    3'd0:    r_dr <= r_acc[7:0];
                    3'd1:    r_cs <= r_acc;
                    3'd2:    r_v1 <= r_acc;
                    3'd3:    r_v2 <= r_acc;
                    default: r_v3 <= r_acc;
                endcase
                r_acc  <= '0;
                r_ds   <= 1'b0;
                r_mode <= M_GROUND;
            end
            if (i_cmd.wr) begin
                r_pal_ok[r_idx] <= 1'b1;
                r_cur           <= r_new;
            end
            if (i_cmd.rd) begin
                r_rd_ok <= r_pal_ok[r_idx];
            end
            if (i_cmd.rd2) begin
                if (r_rd_ok) r_cur <= r_rd_data;
                else if (32'(r_idx) < 16) r_cur <= f_default_rgb(4'(r_idx));
                else r_cur <= '0;
            end
            if (i_cmd.ground) begin
                r_use_rep <= 1'b0;
                if (r_use_rep) begin
                    r_col <= col_sum[16] ? 16'hFFFF : col_sum[15:0];
                end else if (r_byte == CH_REPEAT || r_byte == CH_ATTR
                             || r_byte == CH_COLOUR) begin
                    r_mode <= (r_byte == CH_REPEAT) ? M_REPEAT
                            : (r_byte == CH_ATTR) ? M_ATTR : M_COLOUR;
                    r_fi   <= '0;
                    r_acc  <= '0;
                    r_ds   <= 1'b0;
                    r_dr   <= '0;
                    r_cs   <= '0;
                    r_v1   <= '0;
                    r_v2   <= '0;
                    r_v3   <= '0;
                end else if (r_byte == CH_CR) begin
                    r_col <= '0;
                end else if (r_byte == CH_NL) begin
                    r_col  <= '0;
                    r_band <= (r_band > 16'd65529) ? 16'hFFFF : r_band + 16'd6;
                end else if (is_data) begin
                    r_rep <= 16'd1;
                    r_col <= col_sum[16] ? 16'hFFFF : col_sum[15:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.ground && paint_go) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_x_start    = r_x_start;
    assign o_run_length = r_run_length;
    assign o_band_top   = r_band_top;
    assign o_row_mask   = r_row_mask;
    assign o_red        = r_out_rgb[7:0];
    assign o_green      = r_out_rgb[15:8];
    assign o_blue       = r_out_rgb[23:16];

endmodule

// ===== src/sixel_stream_painter.sv =====
// Sixel body decoder top level: canvas registers, sequencer and datapath.
// A byte is registered on acceptance, classified in PRE and painted in GROUND, which
// loads the run register. A byte that ends a colour definition passes FIN and H1, then
// RD and RD2 for a select, WR for RGB, or H2 to H4 and WR for HLS. Bytes are taken one
// at a time (o_in_stall until IDLE); the last byte adds CLEAR; o_out stalls hold GROUND.
// Reset: synchronous, active low; canvas registers to 1024, palette to defaults (black above entry 15).
module sixel_stream_painter #(
    parameter int MAX_WIDTH       = 1024,
    parameter int MAX_HEIGHT      = 1024,
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_stream_byte,
    input  logic        i_end_of_image,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [9:0]  o_x_start,
    output logic [10:0] o_run_length,
    output logic [9:0]  o_band_top,
    output logic [5:0]  o_row_mask,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ssp_pkg::*;

    logic [10:0] r_canvas_width, r_canvas_height;
    t_cmd  cmd;
    t_stat stat;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? {21'd0, r_canvas_height} : {21'd0, r_canvas_width};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_canvas_width  <= 11'd1024;
            r_canvas_height <= 11'd1024;
        end else if (psel && penable && pwrite) begin
            if (paddr[2]) r_canvas_height <= pwdata[10:0];
            else r_canvas_width <= pwdata[10:0];
        end
    end

    ssp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    ssp_datapath #(
        .MAX_WIDTH       (MAX_WIDTH),
        .MAX_HEIGHT      (MAX_HEIGHT),
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_stream_byte   (i_stream_byte),
        .i_end_of_image  (i_end_of_image),
        .i_canvas_width  (r_canvas_width),
        .i_canvas_height (r_canvas_height),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_x_start       (o_x_start),
        .o_run_length    (o_run_length),
        .o_band_top      (o_band_top),
        .o_row_mask      (o_row_mask),
        .o_red           (o_red),
        .o_green         (o_green),
        .o_blue          (o_blue)
    );

`ifndef NO_ASSERTIONS
    a_mask_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_row_mask != 6'd0) else $error("empty row mask");
    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_run_length != 11'd0) else $error("empty run");
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall) else $error("second byte taken");
`endif

endmodule
